>>> hdl/rsc_pkg.sv
// shared types and constants for the stick calibration block
`timescale 1ns / 1ps
package rsc_pkg;

   localparam int CHANNELS  = 4;
   localparam int VAL_W     = 12;
   localparam int ADDR_W    = 5;

   localparam logic [1:0] CAL_IDLE    = 2'd0;
   localparam logic [1:0] CAL_TRIM    = 2'd1;
   localparam logic [1:0] CAL_RANGE   = 2'd2;
   localparam logic [1:0] CAL_DONE    = 2'd3;

   localparam logic [1:0] CH_ROLL     = 2'd0;
   localparam logic [1:0] CH_PITCH    = 2'd1;
   localparam logic [1:0] CH_THROTTLE = 2'd2;
   localparam logic [1:0] CH_YAW      = 2'd3;

   localparam logic [2:0] REG_RANGE_LOW  = 3'd0;
   localparam logic [2:0] REG_RANGE_HIGH = 3'd1;
   localparam logic [2:0] REG_TRIM_ROLL  = 3'd2;
   localparam logic [2:0] REG_TRIM_PITCH = 3'd3;
   localparam logic [2:0] REG_TRIM_YAW   = 3'd4;

   localparam logic CMD_SAMPLE   = 1'b0;
   localparam logic CMD_SET_STEP = 1'b1;

   typedef struct packed {
      logic        command;
      logic [1:0]  channel;
      logic [15:0] pulse_value;
      logic [1:0]  new_step;
   } req_type;

   typedef struct packed {
      logic signed [7:0] percent;
      logic [11:0]       calibrated_min;
      logic [11:0]       calibrated_max;
      logic [11:0]       calibrated_center;
      logic              value_changed;
      logic [1:0]        current_step;
      logic              finish_request;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic apply_step;
      logic start_avg;
      logic apply_sample;
      logic start_pct;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_step;
      logic avg_needed;
      logic div_done;
      logic out_free;
   } ctrl_status_type;

endpackage

>>> hdl/rsc_div.sv
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rsc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [28:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [28:0] quotient
);
   logic [28:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] dsr_ff, dsr_in;
   logic [4:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [17:0] trial;
   logic [17:0] diff;

   always_comb begin
      trial    = {rem_ff, quot_ff[28]};
      diff     = trial - {1'b0, dsr_ff};
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quot_in  = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         count_in = 5'd28;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in  = diff[16:0];
            quot_in = {quot_ff[27:0], 1'b1};
         end else begin
            rem_in  = trial[16:0];
            quot_in = {quot_ff[27:0], 1'b0};
         end
         count_in = count_ff - 5'd1;
         if (count_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule

>>> hdl/rsc_ctrl.sv
// sequencer for one item: step change or sample, then percent, then result
`timescale 1ns / 1ps
module rsc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rsc_pkg::ctrl_status_type status,
   output rsc_pkg::ctrl_cmd_type   cmd
);
   import rsc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_AVG_WAIT, S_APPLY, S_PCT_SETUP, S_PCT_WAIT, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.is_step) begin
               cmd.apply_step = 1'b1;
               state_in       = S_PCT_SETUP;
            end else if (status.avg_needed) begin
               cmd.start_avg = 1'b1;
               state_in      = S_AVG_WAIT;
            end else begin
               state_in = S_APPLY;
            end
         end
         S_AVG_WAIT: begin
            if (status.div_done) state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply_sample = 1'b1;
            state_in         = S_PCT_SETUP;
         end
         S_PCT_SETUP: begin
            cmd.start_pct = 1'b1;
            state_in      = S_PCT_WAIT;
         end
         S_PCT_WAIT: begin
            if (status.div_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = ready_ff;
endmodule

>>> hdl/rsc_dp.sv
// calibration stores, register bank, percent arithmetic and result register
`timescale 1ns / 1ps
module rsc_dp #(
   parameter logic [11:0] DEFAULT_TRIM = 12'd1500
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rsc_pkg::req_type             req_data,
   input  rsc_pkg::ctrl_cmd_type        cmd,
   output rsc_pkg::ctrl_status_type     status,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output rsc_pkg::rsp_type             rsp_data,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [rsc_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata
);
   import rsc_pkg::*;

   function automatic logic [11:0] abs_diff(input logic [11:0] a, input logic [11:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   logic [11:0] range_low_ff, range_high_ff, trim_roll_ff, trim_pitch_ff, trim_yaw_ff;
   logic [1:0]  step_ff;
   logic [11:0] cur_ff   [CHANNELS];
   logic [11:0] min_ff   [CHANNELS];
   logic [11:0] max_ff   [CHANNELS];
   logic [11:0] ctrim_ff [CHANNELS];
   logic [11:0] avg_ff   [CHANNELS];
   logic [15:0] cnt_ff   [CHANNELS];

   logic        cmd_ff;
   logic [1:0]  ch_ff;
   logic [15:0] val_ff;
   logic [1:0]  ns_ff;
   logic        changed_ff, fin_ff;
   logic        zero_ff, neg_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic        div_start, div_done;
   logic [28:0] div_dividend, div_q;
   logic [16:0] div_divisor;

   logic [2:0]  csr_index;
   logic        csr_write;
   logic [11:0] v12, cur, avg, ctrim, ave, t;
   logic [15:0] cnt;
   logic        in_range, trim_path;
   logic [27:0] avg_prod;
   logic        above, out_lim;
   logic [12:0] span;
   logic [11:0] mag;
   logic [18:0] mag100;
   logic [6:0]  pct_mag;
   logic [7:0]  pct;
   logic [11:0] center;
   logic [12:0] cur_sum;

   assign csr_index = csr_paddr[ADDR_W-1:2];
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_index)
         REG_RANGE_LOW:  csr_prdata = {20'd0, range_low_ff};
         REG_RANGE_HIGH: csr_prdata = {20'd0, range_high_ff};
         REG_TRIM_ROLL:  csr_prdata = {20'd0, trim_roll_ff};
         REG_TRIM_PITCH: csr_prdata = {20'd0, trim_pitch_ff};
         REG_TRIM_YAW:   csr_prdata = {20'd0, trim_yaw_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign v12       = val_ff[11:0];
   assign cur       = cur_ff[ch_ff];
   assign avg       = avg_ff[ch_ff];
   assign cnt       = cnt_ff[ch_ff];
   assign ctrim     = ctrim_ff[ch_ff];
   assign in_range  = (val_ff >= {4'd0, range_low_ff}) && (val_ff <= {4'd0, range_high_ff});
   assign trim_path = (step_ff == CAL_TRIM) && (ch_ff != CH_THROTTLE);
   assign avg_prod  = avg * cnt;
   assign ave       = (cnt != 16'd0) ? div_q[11:0] : v12;
   assign cur_sum   = {1'b0, cur} + {1'b0, v12};

   always_comb begin
      case (ch_ff)
         CH_ROLL:  t = trim_roll_ff;
         CH_PITCH: t = trim_pitch_ff;
         CH_YAW:   t = trim_yaw_ff;
         default:  t = DEFAULT_TRIM;
      endcase
   end

   assign above   = cur > t;
   assign out_lim = (cur < range_low_ff) || (cur > range_high_ff);
   assign span    = above ? {1'b0, range_high_ff} - {1'b0, t} : {1'b0, t} - {1'b0, range_low_ff};
   assign mag     = above ? cur - t : t - cur;
   assign mag100  = mag * 7'd100;

   always_comb begin
      div_start    = cmd.start_avg || cmd.start_pct;
      div_dividend = {1'b0, avg_prod} + {17'd0, v12};
      div_divisor  = {1'b0, cnt} + 17'd1;
      if (cmd.start_pct) begin
         div_dividend = {10'd0, mag100};
         div_divisor  = {5'd0, span[11:0]};
      end
   end

   rsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // quotient saturates at full deflection
   assign pct_mag = (div_q > 29'd100) ? 7'd100 : div_q[6:0];
   always_comb begin
      if (zero_ff)     pct = '0;
      else if (neg_ff) pct = -{1'b0, pct_mag};
      else             pct = {1'b0, pct_mag};
   end

   always_comb begin
      if (ch_ff == CH_THROTTLE)                     center = min_ff[CH_THROTTLE];
      else if (ctrim > 12'd800 && ctrim < 12'd2200) center = ctrim;
      else                                          center = 12'd1500;
   end

   assign status.is_step    = (cmd_ff == CMD_SET_STEP);
   assign status.avg_needed = in_range && trim_path && (cnt != 16'd0);
   assign status.div_done   = div_done;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= 12'd1000;
         range_high_ff <= 12'd2000;
         trim_roll_ff  <= 12'd1500;
         trim_pitch_ff <= 12'd1500;
         trim_yaw_ff   <= 12'd1500;
         step_ff       <= CAL_IDLE;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            cur_ff[i]   <= DEFAULT_TRIM;
            min_ff[i]   <= '0;
            max_ff[i]   <= '0;
            ctrim_ff[i] <= '0;
            avg_ff[i]   <= '0;
            cnt_ff[i]   <= '0;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_RANGE_LOW:  range_low_ff  <= csr_pwdata[11:0];
               REG_RANGE_HIGH: range_high_ff <= csr_pwdata[11:0];
               REG_TRIM_ROLL:  trim_roll_ff  <= csr_pwdata[11:0];
               REG_TRIM_PITCH: trim_pitch_ff <= csr_pwdata[11:0];
               REG_TRIM_YAW:   trim_yaw_ff   <= csr_pwdata[11:0];
               default: ;
            endcase
         end
         if (cmd.apply_step && step_ff != ns_ff) begin
            step_ff <= ns_ff;
            if (ns_ff == CAL_TRIM) begin
               for (int i = 0; i < CHANNELS; i++) begin
                  min_ff[i]   <= '0;
                  max_ff[i]   <= '0;
                  ctrim_ff[i] <= '0;
                  avg_ff[i]   <= '0;
                  cnt_ff[i]   <= '0;
               end
            end
         end
         if (cmd.apply_sample && in_range) begin
            if (trim_path) begin
               if (abs_diff(ave, v12) < 12'd50) begin
                  ctrim_ff[ch_ff] <= v12;
                  avg_ff[ch_ff]   <= ave;
                  cnt_ff[ch_ff]   <= cnt + 16'd1;
               end else if (abs_diff(v12, cur) < 12'd50) begin
                  ctrim_ff[ch_ff] <= v12;
                  avg_ff[ch_ff]   <= cur_sum[12:1];
                  cnt_ff[ch_ff]   <= 16'd2;
               end
            end else if (step_ff == CAL_RANGE) begin
               if (v12 > max_ff[ch_ff]) max_ff[ch_ff] <= v12;
               if (v12 < min_ff[ch_ff] || min_ff[ch_ff] == 12'd0) min_ff[ch_ff] <= v12;
            end
            if (cur != v12) cur_ff[ch_ff] <= v12;
         end
         if (cmd.load_out)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready)     rsp_valid_ff <= 1'b0;
      end
   end

   // item, per-item flags and result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff     <= req_data.command;
         ch_ff      <= req_data.channel;
         val_ff     <= req_data.pulse_value;
         ns_ff      <= req_data.new_step;
         changed_ff <= 1'b0;
         fin_ff     <= 1'b0;
      end
      if (cmd.apply_step && step_ff != ns_ff && ns_ff == CAL_DONE) fin_ff <= 1'b1;
      if (cmd.apply_sample && in_range && cur != v12) changed_ff <= 1'b1;
      if (cmd.start_pct) begin
         zero_ff <= out_lim || span[12] || (span == 13'd0);
         neg_ff  <= !above;
      end
      if (cmd.load_out) begin
         rsp_ff.percent           <= pct;
         rsp_ff.calibrated_min    <= min_ff[ch_ff];
         rsp_ff.calibrated_max    <= max_ff[ch_ff];
         rsp_ff.calibrated_center <= center;
         rsp_ff.value_changed     <= changed_ff;
         rsp_ff.current_step      <= step_ff;
         rsp_ff.finish_request    <= fin_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

>>> hdl/rc_stick_calibration.sv
// top level of the stick calibration block
`timescale 1ns / 1ps
// Each transfer yields one result. A sample in trim step takes longer once
// the channel holds a count: the running average and the percent each go
// through one shared serial divider. A result is held back while an earlier
// result still waits on rsp_ready.
// A result waits in an output register while the next item is taken in.
// Registers sit on an APB port at byte addresses 4*i.
module rc_stick_calibration #(
   parameter logic [11:0] DEFAULT_TRIM = 12'd1500
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rsc_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsc_pkg::rsp_type           rsp_data,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [rsc_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import rsc_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_pready = 1'b1;

   rsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rsc_dp #(.DEFAULT_TRIM(DEFAULT_TRIM)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );
endmodule

>>> hdl/rsc_checker.sv
// port-level checks for the stick calibration block
`timescale 1ns / 1ps
module rsc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsc_pkg::rsp_type rsp_data
);
   import rsc_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_pct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.percent >= -8'sd100) && (rsp_data.percent <= 8'sd100))
      else $error("percent out of range");

   a_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.finish_request |-> rsp_data.current_step == CAL_DONE)
      else $error("finish request without finish step");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.value_changed |-> !rsp_data.finish_request)
      else $error("sample and step change in one result");
endmodule

bind rc_stick_calibration rsc_checker u_rsc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
